/* design/msort_pkg.sv */
// Shared constants, state and command encodings, and status type for the merge-insertion sorter.
`timescale 1ns / 1ps
package msort_pkg;

  localparam int MAX_ITEMS  = 64;
  localparam int VAL_W      = 31;
  localparam int HALF_ITEMS = MAX_ITEMS / 2;
  localparam int CNT_W      = $clog2(MAX_ITEMS + 1);
  localparam int ADDR_W     = $clog2(MAX_ITEMS);
  localparam int PCNT_W     = $clog2(HALF_ITEMS + 1);
  localparam int PADDR_W    = (HALF_ITEMS > 1) ? $clog2(HALF_ITEMS) : 1;
  localparam int JAC_W      = CNT_W + 1;

  typedef enum logic [4:0] {
    S_LOAD,
    S_STRAG_RD,
    S_STRAG_CAP,
    S_PAIR_RD,
    S_PAIR_CMP,
    S_PSORT_RD,
    S_PSORT_CMP,
    S_PSORT_WR,
    S_CHAIN_RD,
    S_CHAIN_WR,
    S_CHAIN_W0,
    S_JAC,
    S_PEND_RD,
    S_PEND_CAP,
    S_SRCH,
    S_SRCH_CMP,
    S_SHIFT,
    S_SHIFT_WR,
    S_NEXT,
    S_OUT_RD,
    S_OUT_CAP,
    S_OUT_WAIT
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_STRAG_RD,
    OP_STRAG_CAP,
    OP_PAIR_RD,
    OP_PAIR_CMP,
    OP_PSORT_RD,
    OP_PSORT_MOVE,
    OP_PSORT_WR,
    OP_CHAIN_RD,
    OP_CHAIN_WR,
    OP_CHAIN_W0,
    OP_JAC_PEND,
    OP_JAC_STRAG,
    OP_PEND_RD,
    OP_PEND_CAP,
    OP_SRCH_RD,
    OP_SRCH_CMP,
    OP_SHIFT_RD,
    OP_SHIFT_WR,
    OP_PLACE,
    OP_PEND_NEXT,
    OP_JAC_STEP,
    OP_OUT_START,
    OP_OUT_RD,
    OP_OUT_CAP,
    OP_OUT_TAKE
  } op_t;

  typedef struct packed {
    logic has_pairs;
    logic np_one;
    logic i_zero;
    logic i_last;
    logic j_one;
    logic big_gt;
    logic jac_more;
    logic has_strag;
    logic pend_more;
    logic ins_strag;
    logic srch_open;
    logic shift_more;
    logic out_final;
  } sts_t;

endpackage

/* design/merge_insertion_sorter_core.sv */
// Top level of the merge-insertion sorter: controller and datapath.
`timescale 1ns / 1ps
// Usage: the item channel (item_valid, item_stall, value, last) loads one list element per
// transaction; the block takes one element per cycle while it is loading. The transaction
// with last set ends the list and starts the sort. Up to 64 elements are kept; further
// elements are dropped and overflow is set on every result of that run.
// The sort uses one chain memory with one write and two read ports plus a pair memory: pairs
// are formed and ordered by their larger member with a linear insertion; the first pair's
// smaller member heads the chain, and the other smaller members and an odd straggler go
// in by binary search in Jacobsthal group order. Each insertion is a binary search over the
// chain, then a shift of each chain entry above the insertion point by one read and one write.
// The result channel (result_valid, result_stall, sorted_value, final_res, overflow)
// then returns the n elements in ascending order, one at a time and the next only once the
// current one is taken; final_res marks the last one. While the receiver stalls, the
// current result is held unchanged. No new item is taken from the last item of a list until
// the final result of its run has been taken. A synchronous reset empties the list and
// clears the overflow flag and any pending result; the block is ready the cycle after.
module merge_insertion_sorter_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_stall,
  input  logic [msort_pkg::VAL_W-1:0] value,
  input  logic                        last,
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic [msort_pkg::VAL_W-1:0] sorted_value,
  output logic                        final_res,
  output logic                        overflow
);

  msort_pkg::op_t  op;
  msort_pkg::sts_t sts;

  msort_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .last         (last),
    .result_stall (result_stall),
    .sts          (sts),
    .op           (op),
    .item_stall   (item_stall)
  );

  msort_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .op           (op),
    .value        (value),
    .sts          (sts),
    .result_valid (result_valid),
    .sorted_value (sorted_value),
    .final_res    (final_res),
    .overflow     (overflow)
  );

endmodule

/* design/msort_ctrl.sv */
// Controller state machine that sequences loading, pair sorting, insertion and readout.
`timescale 1ns / 1ps
module msort_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  logic             last,
  input  logic             result_stall,
  input  msort_pkg::sts_t  sts,
  output msort_pkg::op_t   op,
  output logic             item_stall
);

  msort_pkg::state_t state;
  msort_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= msort_pkg::S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    op         = msort_pkg::OP_NONE;
    item_stall = 1'b1;
    case (state)
      msort_pkg::S_LOAD: begin
        item_stall = 1'b0;
        if (item_valid) begin
          op = msort_pkg::OP_LOAD;
          if (last) begin
            state_next = msort_pkg::S_STRAG_RD;
          end
        end
      end
      msort_pkg::S_STRAG_RD: begin
        op         = msort_pkg::OP_STRAG_RD;
        state_next = msort_pkg::S_STRAG_CAP;
      end
      msort_pkg::S_STRAG_CAP: begin
        op         = msort_pkg::OP_STRAG_CAP;
        state_next = sts.has_pairs ? msort_pkg::S_PAIR_RD : msort_pkg::S_JAC;
      end
      msort_pkg::S_PAIR_RD: begin
        op         = msort_pkg::OP_PAIR_RD;
        state_next = msort_pkg::S_PAIR_CMP;
      end
      msort_pkg::S_PAIR_CMP: begin
        op         = msort_pkg::OP_PAIR_CMP;
        state_next = sts.i_zero ? msort_pkg::S_PSORT_WR : msort_pkg::S_PSORT_RD;
      end
      msort_pkg::S_PSORT_RD: begin
        op         = msort_pkg::OP_PSORT_RD;
        state_next = msort_pkg::S_PSORT_CMP;
      end
      msort_pkg::S_PSORT_CMP: begin
        if (sts.big_gt) begin
          op         = msort_pkg::OP_PSORT_MOVE;
          state_next = sts.j_one ? msort_pkg::S_PSORT_WR : msort_pkg::S_PSORT_RD;
        end else begin
          state_next = msort_pkg::S_PSORT_WR;
        end
      end
      msort_pkg::S_PSORT_WR: begin
        op         = msort_pkg::OP_PSORT_WR;
        state_next = sts.i_last ? msort_pkg::S_CHAIN_RD : msort_pkg::S_PAIR_RD;
      end
      msort_pkg::S_CHAIN_RD: begin
        op         = msort_pkg::OP_CHAIN_RD;
        state_next = msort_pkg::S_CHAIN_WR;
      end
      msort_pkg::S_CHAIN_WR: begin
        op = msort_pkg::OP_CHAIN_WR;
        if (sts.i_zero) begin
          state_next = msort_pkg::S_CHAIN_W0;
        end else if (sts.i_last) begin
          state_next = msort_pkg::S_JAC;
        end else begin
          state_next = msort_pkg::S_CHAIN_RD;
        end
      end
      msort_pkg::S_CHAIN_W0: begin
        op         = msort_pkg::OP_CHAIN_W0;
        state_next = sts.np_one ? msort_pkg::S_JAC : msort_pkg::S_CHAIN_RD;
      end
      msort_pkg::S_JAC: begin
        if (sts.jac_more) begin
          op         = msort_pkg::OP_JAC_PEND;
          state_next = msort_pkg::S_PEND_RD;
        end else if (sts.has_strag) begin
          op         = msort_pkg::OP_JAC_STRAG;
          state_next = msort_pkg::S_SRCH;
        end else begin
          op         = msort_pkg::OP_OUT_START;
          state_next = msort_pkg::S_OUT_RD;
        end
      end
      msort_pkg::S_PEND_RD: begin
        op         = msort_pkg::OP_PEND_RD;
        state_next = msort_pkg::S_PEND_CAP;
      end
      msort_pkg::S_PEND_CAP: begin
        op         = msort_pkg::OP_PEND_CAP;
        state_next = msort_pkg::S_SRCH;
      end
      msort_pkg::S_SRCH: begin
        if (sts.srch_open) begin
          op         = msort_pkg::OP_SRCH_RD;
          state_next = msort_pkg::S_SRCH_CMP;
        end else begin
          state_next = msort_pkg::S_SHIFT;
        end
      end
      msort_pkg::S_SRCH_CMP: begin
        op         = msort_pkg::OP_SRCH_CMP;
        state_next = msort_pkg::S_SRCH;
      end
      msort_pkg::S_SHIFT: begin
        if (sts.shift_more) begin
          op         = msort_pkg::OP_SHIFT_RD;
          state_next = msort_pkg::S_SHIFT_WR;
        end else begin
          op         = msort_pkg::OP_PLACE;
          state_next = msort_pkg::S_NEXT;
        end
      end
      msort_pkg::S_SHIFT_WR: begin
        op         = msort_pkg::OP_SHIFT_WR;
        state_next = msort_pkg::S_SHIFT;
      end
      msort_pkg::S_NEXT: begin
        if (sts.ins_strag) begin
          op         = msort_pkg::OP_OUT_START;
          state_next = msort_pkg::S_OUT_RD;
        end else if (sts.pend_more) begin
          op         = msort_pkg::OP_PEND_NEXT;
          state_next = msort_pkg::S_PEND_RD;
        end else begin
          op         = msort_pkg::OP_JAC_STEP;
          state_next = msort_pkg::S_JAC;
        end
      end
      msort_pkg::S_OUT_RD: begin
        op         = msort_pkg::OP_OUT_RD;
        state_next = msort_pkg::S_OUT_CAP;
      end
      msort_pkg::S_OUT_CAP: begin
        op         = msort_pkg::OP_OUT_CAP;
        state_next = msort_pkg::S_OUT_WAIT;
      end
      msort_pkg::S_OUT_WAIT: begin
        if (!result_stall) begin
          op         = msort_pkg::OP_OUT_TAKE;
          state_next = sts.out_final ? msort_pkg::S_LOAD : msort_pkg::S_OUT_RD;
        end
      end
      default: begin
        state_next = msort_pkg::S_LOAD;
      end
    endcase
  end

endmodule

/* design/msort_datapath.sv */
// Datapath with the chain and pair memories, index registers, comparators and result register.
`timescale 1ns / 1ps
module msort_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  msort_pkg::op_t                  op,
  input  logic [msort_pkg::VAL_W-1:0]     value,
  output msort_pkg::sts_t                 sts,
  output logic                            result_valid,
  output logic [msort_pkg::VAL_W-1:0]     sorted_value,
  output logic                            final_res,
  output logic                            overflow
);

  logic [msort_pkg::VAL_W-1:0] chain_mem [msort_pkg::MAX_ITEMS];
  logic [msort_pkg::VAL_W-1:0] big_mem   [msort_pkg::HALF_ITEMS];
  logic [msort_pkg::VAL_W-1:0] small_mem [msort_pkg::HALF_ITEMS];

  logic [msort_pkg::CNT_W-1:0]  cnt;
  logic                         dropped;
  logic [msort_pkg::VAL_W-1:0]  strag;
  logic [msort_pkg::PCNT_W-1:0] i;
  logic [msort_pkg::PCNT_W-1:0] j;
  logic [msort_pkg::VAL_W-1:0]  kb;
  logic [msort_pkg::VAL_W-1:0]  ks;
  logic [msort_pkg::CNT_W-1:0]  len;
  logic [msort_pkg::CNT_W-1:0]  lo;
  logic [msort_pkg::CNT_W-1:0]  hi;
  logic [msort_pkg::CNT_W-1:0]  k;
  logic [msort_pkg::VAL_W-1:0]  v;
  logic [msort_pkg::JAC_W-1:0]  prev;
  logic [msort_pkg::JAC_W-1:0]  ja;
  logic [msort_pkg::JAC_W-1:0]  jb;
  logic                         ins_strag;

  logic [msort_pkg::VAL_W-1:0]  rd_a;
  logic [msort_pkg::VAL_W-1:0]  rd_b;
  logic [msort_pkg::VAL_W-1:0]  rd_big;
  logic [msort_pkg::VAL_W-1:0]  rd_small;

  logic                          ch_we;
  logic [msort_pkg::ADDR_W-1:0]  ch_waddr;
  logic [msort_pkg::VAL_W-1:0]   ch_wdata;
  logic                          ch_re_a;
  logic [msort_pkg::ADDR_W-1:0]  ch_raddr_a;
  logic                          ch_re_b;
  logic [msort_pkg::ADDR_W-1:0]  ch_raddr_b;
  logic                          p_we;
  logic [msort_pkg::PADDR_W-1:0] p_waddr;
  logic [msort_pkg::VAL_W-1:0]   p_wbig;
  logic [msort_pkg::VAL_W-1:0]   p_wsmall;
  logic                          p_re;
  logic [msort_pkg::PADDR_W-1:0] p_raddr;

  logic [msort_pkg::PCNT_W-1:0] np;
  logic [msort_pkg::JAC_W-1:0]  np_j;
  logic [msort_pkg::JAC_W-1:0]  top;
  logic [msort_pkg::CNT_W:0]    mid_sum;
  logic [msort_pkg::CNT_W-1:0]  mid;
  logic [msort_pkg::PCNT_W-1:0] j_dec;
  logic                         cnt_room;

  assign np       = msort_pkg::PCNT_W'(cnt >> 1);
  assign np_j     = msort_pkg::JAC_W'(np);
  assign top      = (jb < np_j) ? jb : np_j;
  assign mid_sum  = {1'b0, lo} + {1'b0, hi};
  assign mid      = mid_sum[msort_pkg::CNT_W:1];
  assign j_dec    = j - msort_pkg::PCNT_W'(1);
  assign cnt_room = cnt < msort_pkg::CNT_W'(msort_pkg::MAX_ITEMS);

  always_comb begin
    sts.has_pairs  = np != '0;
    sts.np_one     = np == msort_pkg::PCNT_W'(1);
    sts.i_zero     = i == '0;
    sts.i_last     = i == (np - msort_pkg::PCNT_W'(1));
    sts.j_one      = j == msort_pkg::PCNT_W'(1);
    sts.big_gt     = rd_big > kb;
    sts.jac_more   = prev < np_j;
    sts.has_strag  = cnt[0];
    sts.pend_more  = msort_pkg::JAC_W'(j) > (prev + msort_pkg::JAC_W'(1));
    sts.ins_strag  = ins_strag;
    sts.srch_open  = lo < hi;
    sts.shift_more = k > lo;
    sts.out_final  = (k + msort_pkg::CNT_W'(1)) == cnt;
  end

  always_comb begin
    ch_we      = 1'b0;
    ch_waddr   = '0;
    ch_wdata   = rd_a;
    ch_re_a    = 1'b0;
    ch_raddr_a = '0;
    ch_re_b    = 1'b0;
    ch_raddr_b = '0;
    p_we       = 1'b0;
    p_waddr    = j[msort_pkg::PADDR_W-1:0];
    p_wbig     = kb;
    p_wsmall   = ks;
    p_re       = 1'b0;
    p_raddr    = j_dec[msort_pkg::PADDR_W-1:0];
    case (op)
      msort_pkg::OP_LOAD: begin
        ch_we    = cnt_room;
        ch_waddr = cnt[msort_pkg::ADDR_W-1:0];
        ch_wdata = value;
      end
      msort_pkg::OP_STRAG_RD: begin
        ch_re_a    = 1'b1;
        ch_raddr_a = msort_pkg::ADDR_W'(cnt - msort_pkg::CNT_W'(1));
      end
      msort_pkg::OP_PAIR_RD: begin
        ch_re_a    = 1'b1;
        ch_raddr_a = msort_pkg::ADDR_W'({i, 1'b0});
        ch_re_b    = 1'b1;
        ch_raddr_b = msort_pkg::ADDR_W'({i, 1'b1});
      end
      msort_pkg::OP_PSORT_RD, msort_pkg::OP_PEND_RD: begin
        p_re = 1'b1;
      end
      msort_pkg::OP_PSORT_MOVE: begin
        p_we     = 1'b1;
        p_wbig   = rd_big;
        p_wsmall = rd_small;
      end
      msort_pkg::OP_PSORT_WR: begin
        p_we = 1'b1;
      end
      msort_pkg::OP_CHAIN_RD: begin
        p_re    = 1'b1;
        p_raddr = i[msort_pkg::PADDR_W-1:0];
      end
      msort_pkg::OP_CHAIN_WR: begin
        ch_we    = 1'b1;
        ch_waddr = msort_pkg::ADDR_W'(i) + msort_pkg::ADDR_W'(1);
        ch_wdata = rd_big;
      end
      msort_pkg::OP_CHAIN_W0: begin
        ch_we    = 1'b1;
        ch_waddr = '0;
        ch_wdata = rd_small;
      end
      msort_pkg::OP_SRCH_RD: begin
        ch_re_a    = 1'b1;
        ch_raddr_a = mid[msort_pkg::ADDR_W-1:0];
      end
      msort_pkg::OP_SHIFT_RD: begin
        ch_re_a    = 1'b1;
        ch_raddr_a = msort_pkg::ADDR_W'(k - msort_pkg::CNT_W'(1));
      end
      msort_pkg::OP_SHIFT_WR: begin
        ch_we    = 1'b1;
        ch_waddr = k[msort_pkg::ADDR_W-1:0];
        ch_wdata = rd_a;
      end
      msort_pkg::OP_PLACE: begin
        ch_we    = 1'b1;
        ch_waddr = lo[msort_pkg::ADDR_W-1:0];
        ch_wdata = v;
      end
      msort_pkg::OP_OUT_RD: begin
        ch_re_a    = 1'b1;
        ch_raddr_a = k[msort_pkg::ADDR_W-1:0];
      end
      default: begin
        ch_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ch_we) begin
      chain_mem[ch_waddr] <= ch_wdata;
    end
    if (ch_re_a) begin
      rd_a <= chain_mem[ch_raddr_a];
    end
    if (ch_re_b) begin
      rd_b <= chain_mem[ch_raddr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (p_we) begin
      big_mem[p_waddr]   <= p_wbig;
      small_mem[p_waddr] <= p_wsmall;
    end
    if (p_re) begin
      rd_big   <= big_mem[p_raddr];
      rd_small <= small_mem[p_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt          <= '0;
      dropped      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      case (op)
        msort_pkg::OP_LOAD: begin
          if (cnt_room) begin
            cnt <= cnt + msort_pkg::CNT_W'(1);
          end else begin
            dropped <= 1'b1;
          end
        end
        msort_pkg::OP_OUT_CAP: begin
          result_valid <= 1'b1;
        end
        msort_pkg::OP_OUT_TAKE: begin
          result_valid <= 1'b0;
          if (sts.out_final) begin
            cnt     <= '0;
            dropped <= 1'b0;
          end
        end
        default: begin
          result_valid <= result_valid;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      msort_pkg::OP_STRAG_CAP: begin
        strag     <= rd_a;
        i         <= '0;
        len       <= '0;
        prev      <= msort_pkg::JAC_W'(1);
        ja        <= msort_pkg::JAC_W'(1);
        jb        <= msort_pkg::JAC_W'(3);
        ins_strag <= 1'b0;
      end
      msort_pkg::OP_PAIR_CMP: begin
        kb <= (rd_a > rd_b) ? rd_a : rd_b;
        ks <= (rd_a > rd_b) ? rd_b : rd_a;
        j  <= i;
      end
      msort_pkg::OP_PSORT_MOVE: begin
        j <= j_dec;
      end
      msort_pkg::OP_PSORT_WR: begin
        i <= sts.i_last ? '0 : i + msort_pkg::PCNT_W'(1);
      end
      msort_pkg::OP_CHAIN_WR: begin
        len <= len + msort_pkg::CNT_W'(1);
        if (!sts.i_last) begin
          i <= i + msort_pkg::PCNT_W'(1);
        end
      end
      msort_pkg::OP_CHAIN_W0: begin
        len <= len + msort_pkg::CNT_W'(1);
      end
      msort_pkg::OP_JAC_PEND: begin
        j <= msort_pkg::PCNT_W'(top);
      end
      msort_pkg::OP_JAC_STRAG: begin
        v         <= strag;
        lo        <= '0;
        hi        <= len;
        k         <= len;
        ins_strag <= 1'b1;
      end
      msort_pkg::OP_PEND_CAP: begin
        v  <= rd_small;
        lo <= '0;
        hi <= len;
        k  <= len;
      end
      msort_pkg::OP_SRCH_CMP: begin
        if (rd_a < v) begin
          lo <= mid + msort_pkg::CNT_W'(1);
        end else begin
          hi <= mid;
        end
      end
      msort_pkg::OP_SHIFT_WR: begin
        k <= k - msort_pkg::CNT_W'(1);
      end
      msort_pkg::OP_PLACE: begin
        len <= len + msort_pkg::CNT_W'(1);
      end
      msort_pkg::OP_PEND_NEXT: begin
        j <= j_dec;
      end
      msort_pkg::OP_JAC_STEP: begin
        prev <= jb;
        ja   <= jb;
        jb   <= jb + (ja << 1);
      end
      msort_pkg::OP_OUT_START: begin
        k <= '0;
      end
      msort_pkg::OP_OUT_CAP: begin
        sorted_value <= rd_a;
        final_res    <= sts.out_final;
        overflow     <= dropped;
      end
      msort_pkg::OP_OUT_TAKE: begin
        if (!sts.out_final) begin
          k <= k + msort_pkg::CNT_W'(1);
        end
      end
      default: begin
        v <= v;
      end
    endcase
  end

  // The chain never grows past the number of loaded items.
  a_place_room: assert property (@(posedge clk) disable iff (rst)
    (op == msort_pkg::OP_PLACE) |-> (len < cnt))
    else $error("chain insertion beyond the loaded item count");

  // A search probe always lands inside the current chain.
  a_probe_in_chain: assert property (@(posedge clk) disable iff (rst)
    (op == msort_pkg::OP_SRCH_RD) |-> (mid < len))
    else $error("binary search probe outside the chain");

  // A pair is never placed above the slot it was formed for.
  a_pair_slot: assert property (@(posedge clk) disable iff (rst)
    (op == msort_pkg::OP_PSORT_WR) |-> (j <= i))
    else $error("pair placed above its own slot");

  // A result is only presented while a loaded run exists.
  a_result_has_run: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (cnt != '0))
    else $error("result presented with no loaded items");

endmodule
